[hdl/ppmq_pkg.sv]
package ppmq_pkg;

    // Sizing
    localparam int MAILBOXES   = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int MSG_BYTES   = 8;
    localparam int PID_BITS    = 16;

    // Field widths
    localparam int PID_W    = 16;
    localparam int TYPE_W   = 32;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 4;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int MB_W   = $clog2(MAILBOXES);
    localparam int QH_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS  = MAILBOXES * QUEUE_DEPTH;
    localparam int SLOT_W = $clog2(SLOTS);

    // Owner search: groups of eight, then a pick over the groups
    localparam int GRP    = 8;
    localparam int GRP_W  = 3;
    localparam int NGRP   = (MAILBOXES + GRP - 1) / GRP;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [PID_W-1:0] PID_MASK = (PID_BITS >= PID_W) ? {PID_W{1'b1}} :
                                            PID_W'((64'd1 << PID_BITS) - 64'd1);
    localparam logic [SIZE_W-1:0] MSG_BYTES_C = SIZE_W'(MSG_BYTES);

    // Stream widths, whole bytes
    localparam int IN_BITS     = PID_W + 1 + PID_W + TYPE_W + DATA_W + SIZE_W + SIZE_W;
    localparam int IN_TDATA_W  = (IN_BITS + 7) / 8 * 8;
    localparam int OUT_BITS    = PID_W + TYPE_W + DATA_W + SIZE_W + 1 + PID_W;
    localparam int OUT_TDATA_W = (OUT_BITS + 7) / 8 * 8;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NO_CAP  = 2'd1,
        STS_NO_MBOX = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_QRD,
        ST_FIN
    } t_state;

    // Input item, first field in the low bits
    typedef struct packed {
        logic [IN_TDATA_W-IN_BITS-1:0] pad;
        logic [SIZE_W-1:0]             receive_max;
        logic [SIZE_W-1:0]             payload_size;
        logic [DATA_W-1:0]             payload;
        logic [TYPE_W-1:0]             msg_type;
        logic [PID_W-1:0]              dest_pid;
        logic                          caller_may_ipc;
        logic [PID_W-1:0]              caller_pid;
    } t_in_data;

    // Result item, first field in the low bits
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
        logic [PID_W-1:0]                wake_pid;
        logic                            wake_valid;
        logic [SIZE_W-1:0]               copied_size;
        logic [DATA_W-1:0]               recv_payload;
        logic [TYPE_W-1:0]               recv_type;
        logic [PID_W-1:0]                sender_pid;
    } t_out_data;

    // One stored message
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] payload;
        logic [PID_W-1:0]  sender;
        logic [TYPE_W-1:0] mtype;
    } t_msg;

    // Ring state of one mailbox
    typedef struct packed {
        logic [QH_W-1:0] head;
        logic [QC_W-1:0] count;
    } t_qstate;

    typedef struct packed {
        logic            found;
        logic            claim;
        logic [MB_W-1:0] mb;
    } t_match;

    typedef struct packed {
        logic             en;
        logic [MB_W-1:0]  idx;
        logic [PID_W-1:0] pid;
    } t_owner_wr;

    // Keep the low n bytes
    function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] m;
        int b;
        m = '0;
        for (b = 0; b < DATA_W / 8; b++) begin
            m[b*8 +: 8] = (n > SIZE_W'(b)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[hdl/ppmq_ram.sv]
module ppmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ppmq_owner_cam.sv]
module ppmq_owner_cam (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_search,
    input  logic [ppmq_pkg::PID_W-1:0]    i_pid,
    input  ppmq_pkg::t_owner_wr           i_wr,
    output ppmq_pkg::t_match              o_match
);
    import ppmq_pkg::*;

    logic [PID_W-1:0] r_owner [MAILBOXES];

    logic [NGRP-1:0]  r_hit_any, n_hit_any;
    logic [NGRP-1:0]  r_free_any, n_free_any;
    logic [GRP_W-1:0] r_hit_idx [NGRP];
    logic [GRP_W-1:0] n_hit_idx [NGRP];
    logic [GRP_W-1:0] r_free_idx [NGRP];
    logic [GRP_W-1:0] n_free_idx [NGRP];

    // First stage: compare every owner, lowest hit inside each group of eight
    always_comb begin
        int g;
        int j;
        int e;
        for (g = 0; g < NGRP; g++) begin
            n_hit_any[g]  = 1'b0;
            n_free_any[g] = 1'b0;
            n_hit_idx[g]  = '0;
            n_free_idx[g] = '0;
            for (j = GRP - 1; j >= 0; j--) begin
                e = g * GRP + j;
                if (e < MAILBOXES) begin
                    if (r_owner[MB_W'(e)] == i_pid) begin
                        n_hit_any[g] = 1'b1;
                        n_hit_idx[g] = GRP_W'(j);
                    end
                    if (r_owner[MB_W'(e)] == '0) begin
                        n_free_any[g] = 1'b1;
                        n_free_idx[g] = GRP_W'(j);
                    end
                end
            end
        end
    end

    // Owner table and stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAILBOXES; k++) begin
                r_owner[k] <= '0;
            end
            r_hit_any  <= '0;
            r_free_any <= '0;
        end else begin
            if (i_wr.en) begin
                r_owner[i_wr.idx] <= i_wr.pid;
            end
            if (i_search) begin
                r_hit_any  <= n_hit_any;
                r_free_any <= n_free_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_search) begin
            for (int k = 0; k < NGRP; k++) begin
                r_hit_idx[k]  <= n_hit_idx[k];
                r_free_idx[k] <= n_free_idx[k];
            end
        end
    end

    // Second stage: lowest group, a match beats a free slot
    always_comb begin
        logic              hit;
        logic              free;
        logic [NGRP_W-1:0] hg;
        logic [NGRP_W-1:0] fg;
        logic [GRP_W-1:0]  hi;
        logic [GRP_W-1:0]  fi;
        int g;
        hit  = 1'b0;
        free = 1'b0;
        hg   = '0;
        fg   = '0;
        hi   = '0;
        fi   = '0;
        for (g = NGRP - 1; g >= 0; g--) begin
            if (r_hit_any[g]) begin
                hit = 1'b1;
                hg  = NGRP_W'(g);
                hi  = r_hit_idx[g];
            end
            if (r_free_any[g]) begin
                free = 1'b1;
                fg   = NGRP_W'(g);
                fi   = r_free_idx[g];
            end
        end
        o_match.found = hit | free;
        o_match.claim = !hit && free;
        o_match.mb    = hit ? MB_W'({hg, hi}) : MB_W'({fg, fi});
    end

endmodule

[hdl/per_process_mailbox_queue_core.sv]
// Each item passes MATCH, PICK, QRD and FIN; FIN loads the result into the output
// register once it is free. New items are taken only in IDLE, so the two-stage owner
// search, the mailbox ring read-modify-write and the message memory read run in turn.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) frees all mailboxes; the message memory is not
// initialized.
module per_process_mailbox_queue_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // caller_pid, caller_may_ipc, dest_pid, msg_type, payload, payload_size, receive_max
    input  logic [ppmq_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // kind
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // sender_pid, recv_type, recv_payload, copied_size, wake_valid, wake_pid
    output logic [ppmq_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // status
    output logic [ppmq_pkg::STATUS_W-1:0]      o_m_tuser
);
    import ppmq_pkg::*;

    t_state r_state, n_state;

    // FSM outputs
    logic s_ready, cam_search, q_re, exec, fin;
    logic out_free, out_load, in_fire;

    // Captured item
    logic              r_kind, r_ipc;
    logic [PID_W-1:0]  r_caller, r_dest, r_pid;
    logic [TYPE_W-1:0] r_type;
    logic [DATA_W-1:0] r_payload;
    logic [SIZE_W-1:0] r_size, r_rmax;
    t_in_data          in_d;

    // Search result
    t_match            cam_match;
    logic [MB_W-1:0]   r_mb;
    logic              r_found, r_claim;
    t_owner_wr         owner_wr;

    // Ring state
    logic [MAILBOXES-1:0] r_qvalid;
    t_qstate           q_rd, q_wdata;
    logic [QH_W-1:0]   eff_head, head_inc, pos;
    logic [QC_W-1:0]   eff_cnt;
    logic [QC_W:0]     pos_sum;
    logic              eff_ok, do_op, is_send, full, empty, q_we;
    logic [SLOT_W-1:0] mb_base, wr_slot, rd_slot;
    logic [SIZE_W-1:0] size_c;

    // Message store
    t_msg              msg_wdata, msg_rd;
    logic              msg_we, msg_re;

    // Result control
    t_status           r_status, n_status;
    logic              r_rx, r_wake;
    logic [SIZE_W-1:0] copy_n;
    t_out_data         out_d, r_out_d;
    t_status           r_out_status;
    logic              r_out_valid;

    assign in_d     = t_in_data'(i_s_tdata);
    assign in_fire  = i_s_tvalid && s_ready;
    assign out_free = !r_out_valid || i_m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_tvalid) n_state = ST_MATCH;
            ST_MATCH: n_state = ST_PICK;
            ST_PICK:  n_state = ST_QRD;
            ST_QRD:   n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready    = 1'b0;
        cam_search = 1'b0;
        q_re       = 1'b0;
        exec       = 1'b0;
        fin        = 1'b0;
        case (r_state)
            ST_IDLE:  s_ready    = 1'b1;
            ST_MATCH: cam_search = 1'b1;
            ST_PICK:  q_re       = 1'b1;
            ST_QRD:   exec       = 1'b1;
            ST_FIN:   fin        = 1'b1;
            default:  s_ready    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item; the search key is the mailbox pid
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind    <= i_s_tuser;
            r_ipc     <= in_d.caller_may_ipc;
            r_caller  <= in_d.caller_pid & PID_MASK;
            r_dest    <= in_d.dest_pid & PID_MASK;
            r_type    <= in_d.msg_type;
            r_payload <= in_d.payload;
            r_size    <= in_d.payload_size;
            r_rmax    <= in_d.receive_max;
            r_pid     <= ((i_s_tuser == KIND_RECV) ? in_d.caller_pid : in_d.dest_pid)
                         & PID_MASK;
        end
    end

    ppmq_owner_cam u_cam (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_search (cam_search),
        .i_pid    (r_pid),
        .i_wr     (owner_wr),
        .o_match  (cam_match)
    );

    always_ff @(posedge i_clk) begin
        if (q_re) begin
            r_mb    <= cam_match.mb;
            r_found <= cam_match.found;
            r_claim <= cam_match.claim;
        end
    end

    // Ring state memory, read at the pick, written back in the following cycle
    ppmq_ram #(.WIDTH($bits(t_qstate)), .DEPTH(MAILBOXES)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_mb),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (cam_match.mb),
        .o_rdata (q_rd)
    );

    // A never-written or just-claimed mailbox reads as empty
    always_comb begin
        eff_ok   = r_qvalid[r_mb] && !r_claim;
        eff_head = eff_ok ? q_rd.head  : '0;
        eff_cnt  = eff_ok ? q_rd.count : '0;
        do_op    = r_ipc && r_found;
        is_send  = (r_kind == KIND_SEND);
        full     = (eff_cnt == QC_W'(QUEUE_DEPTH));
        empty    = (eff_cnt == '0);
        pos_sum  = (QC_W+1)'(eff_head) + (QC_W+1)'(eff_cnt);
        pos      = (pos_sum >= (QC_W+1)'(QUEUE_DEPTH)) ?
                   QH_W'(pos_sum - (QC_W+1)'(QUEUE_DEPTH)) : QH_W'(pos_sum);
        head_inc = (eff_head == QH_W'(QUEUE_DEPTH - 1)) ? '0 : eff_head + QH_W'(1);
        mb_base  = SLOT_W'(r_mb) * SLOT_W'(QUEUE_DEPTH);
        wr_slot  = mb_base + SLOT_W'(pos);
        rd_slot  = mb_base + SLOT_W'(eff_head);
        size_c   = (r_size > MSG_BYTES_C) ? MSG_BYTES_C : r_size;
    end

    // Updates of one operation
    always_comb begin
        q_we   = exec && do_op;
        msg_we = exec && do_op && is_send && !full;
        msg_re = exec && do_op && !is_send && !empty;

        q_wdata.head  = eff_head;
        q_wdata.count = eff_cnt;
        if (is_send) begin
            if (!full) q_wdata.count = eff_cnt + QC_W'(1);
        end else if (!empty) begin
            q_wdata.head  = head_inc;
            q_wdata.count = eff_cnt - QC_W'(1);
        end

        owner_wr.en  = exec && do_op && r_claim;
        owner_wr.idx = r_mb;
        owner_wr.pid = r_pid;

        msg_wdata.size    = size_c;
        msg_wdata.payload = r_payload & byte_mask(size_c);
        msg_wdata.sender  = r_caller;
        msg_wdata.mtype   = r_type;

        if (!r_ipc)       n_status = STS_NO_CAP;
        else if (!r_found) n_status = STS_NO_MBOX;
        else if (is_send)  n_status = STS_OK;
        else if (empty)    n_status = STS_EMPTY;
        else               n_status = STS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvalid <= '0;
        end else if (q_we) begin
            r_qvalid[r_mb] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_rx     <= msg_re;
            r_wake   <= do_op && is_send;
        end
    end

    // Message memory, one entry per ring slot
    ppmq_ram #(.WIDTH($bits(t_msg)), .DEPTH(SLOTS)) u_mram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (wr_slot),
        .i_wdata (msg_wdata),
        .i_re    (msg_re),
        .i_raddr (rd_slot),
        .o_rdata (msg_rd)
    );

    // Build the result
    always_comb begin
        copy_n = '0;
        if (r_rx) copy_n = (msg_rd.size > r_rmax) ? r_rmax : msg_rd.size;
        out_d              = '0;
        out_d.sender_pid   = r_rx ? msg_rd.sender : '0;
        out_d.recv_type    = r_rx ? msg_rd.mtype  : '0;
        out_d.recv_payload = r_rx ? (msg_rd.payload & byte_mask(copy_n)) : '0;
        out_d.copied_size  = copy_n;
        out_d.wake_valid   = r_wake;
        out_d.wake_pid     = r_wake ? r_dest : '0;
        out_load           = fin && out_free;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_d      <= out_d;
            r_out_status <= r_status;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_d;
    assign o_m_tuser  = r_out_status;

`ifndef SYNTH
    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_MATCH))
        else $error("accepted item did not start the owner search");

    a_claim_nonzero_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        owner_wr.en |-> (owner_wr.pid != '0))
        else $error("mailbox claimed for pid zero");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_we |-> (q_wdata.count <= QC_W'(QUEUE_DEPTH)))
        else $error("ring count beyond queue depth");

    a_wake_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_d.wake_valid) |-> (r_out_status == STS_OK))
        else $error("wake request with a failing status");
`endif

endmodule

[dv/per_process_mailbox_queue_core_tb.sv]
module per_process_mailbox_queue_core_tb;
    import ppmq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 8;
    localparam int POOL_W      = $clog2(POOL_SIZE);
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;

    // One expected result item: status plus the packed result fields
    typedef struct {
        t_status   status;
        t_out_data data;
    } t_reply;

    // Shadow copy of the mailboxes; predicts each reply and checks the real one
    class mailbox_shadow;
        logic [PID_W-1:0] owner [MAILBOXES];
        int unsigned      head  [MAILBOXES];
        int unsigned      count [MAILBOXES];
        t_msg             msg_mem [SLOTS];
        t_reply           pending_replies [$];
        int               mismatches;
        int               replies_seen;
        int               status_seen [4];
        int               full_drops;

        function new();
            for (int i = 0; i < MAILBOXES; i++) begin
                owner[i] = '0;
                head[i]  = 0;
                count[i] = 0;
            end
            for (int i = 0; i < 4; i++) begin
                status_seen[i] = 0;
            end
            mismatches   = 0;
            replies_seen = 0;
            full_drops   = 0;
        endfunction

        // Lowest owned slot wins, else the lowest free one is claimed.
        // Pid zero matches a free slot in the first pass and so never claims.
        function int find_mailbox_for(logic [PID_W-1:0] pid);
            for (int i = 0; i < MAILBOXES; i++) begin
                if (owner[i] == pid) return i;
            end
            for (int i = 0; i < MAILBOXES; i++) begin
                if (owner[i] == '0) begin
                    owner[i] = pid;
                    head[i]  = 0;
                    count[i] = 0;
                    return i;
                end
            end
            return -1;
        endfunction

        function logic [DATA_W-1:0] keep_bytes(logic [DATA_W-1:0] data, int unsigned n);
            if (n >= DATA_W / 8) return data;
            return data & ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        // Accepted request: update the shadow state and queue the reply
        function void note_request(logic kind, t_in_data d);
            t_reply           r;
            int               mb;
            int unsigned      slot;
            int unsigned      n;
            logic [PID_W-1:0] caller;
            logic [PID_W-1:0] dest;
            r.status = STS_OK;
            r.data   = '0;
            caller   = d.caller_pid & PID_MASK;
            dest     = d.dest_pid & PID_MASK;
            if (!d.caller_may_ipc) begin
                r.status = STS_NO_CAP;
            end else if (kind == KIND_SEND) begin
                mb = find_mailbox_for(dest);
                if (mb < 0) begin
                    r.status = STS_NO_MBOX;
                end else begin
                    n = (d.payload_size > MSG_BYTES_C) ? MSG_BYTES : 32'(d.payload_size);
                    if (count[mb] < QUEUE_DEPTH) begin
                        slot = mb * QUEUE_DEPTH + (head[mb] + count[mb]) % QUEUE_DEPTH;
                        msg_mem[slot].sender  = caller;
                        msg_mem[slot].mtype   = d.msg_type;
                        msg_mem[slot].payload = keep_bytes(d.payload, n);
                        msg_mem[slot].size    = SIZE_W'(n);
                        count[mb]++;
                    end else begin
                        // full queue: dropped, wake still requested
                        full_drops++;
                    end
                    r.data.wake_valid = 1'b1;
                    r.data.wake_pid   = dest;
                end
            end else begin
                mb = find_mailbox_for(caller);
                if (mb < 0) begin
                    r.status = STS_NO_MBOX;
                end else if (count[mb] == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    slot = mb * QUEUE_DEPTH + head[mb];
                    n    = 32'(msg_mem[slot].size);
                    if (n > d.receive_max) n = 32'(d.receive_max);
                    head[mb] = (head[mb] + 1) % QUEUE_DEPTH;
                    count[mb]--;
                    r.data.sender_pid   = msg_mem[slot].sender;
                    r.data.recv_type    = msg_mem[slot].mtype;
                    r.data.recv_payload = keep_bytes(msg_mem[slot].payload, n);
                    r.data.copied_size  = SIZE_W'(n);
                end
            end
            status_seen[r.status]++;
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reply %0d: %s expected %h, got %h", replies_seen, name, want, got);
                end
            end
        endfunction

        // Accepted result: compare with the oldest prediction
        function void check_reply(logic [STATUS_W-1:0] status, t_out_data got);
            t_reply want;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reply %0d arrived with nothing outstanding", replies_seen);
                end
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status",       DATA_W'(want.status),          DATA_W'(status));
            compare_field("sender_pid",   DATA_W'(want.data.sender_pid), DATA_W'(got.sender_pid));
            compare_field("recv_type",    DATA_W'(want.data.recv_type),  DATA_W'(got.recv_type));
            compare_field("recv_payload", want.data.recv_payload,        got.recv_payload);
            compare_field("copied_size",  DATA_W'(want.data.copied_size),
                          DATA_W'(got.copied_size));
            compare_field("wake_valid",   DATA_W'(want.data.wake_valid), DATA_W'(got.wake_valid));
            compare_field("wake_pid",     DATA_W'(want.data.wake_pid),   DATA_W'(got.wake_pid));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    t_in_data            i_s_tdata  = '0;
    logic                i_s_tuser  = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    t_out_data           o_m_tdata;
    logic [STATUS_W-1:0] o_m_tuser;

    mailbox_shadow    shadow = new();
    logic [PID_W-1:0] pid_pool [POOL_SIZE];
    bit               quiet_tail      = 1'b0;
    int               hold_off_cycles = 0;
    int               items_sent      = 0;
    int               cycle_count     = 0;

    per_process_mailbox_queue_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("per_process_mailbox_queue_core_tb: FAIL");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            shadow.check_reply(o_m_tuser, o_m_tdata);
        end
    end

    // Result sink: random stall bursts, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_m_tready <= 1'b0;
                hold_off_cycles--;
            end else if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                stall = $urandom_range(1, 6) - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offer one request, with an occasional gap first; valid stays high after
    // acceptance so that back-to-back items see a single assignment per step
    task automatic offer(input logic kind, input t_in_data d);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        shadow.note_request(kind, d);
        items_sent++;
    endtask

    // Stop offering until every reply is back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (shadow.pending_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_data pack_req(logic [PID_W-1:0] caller, logic may_ipc,
                                          logic [PID_W-1:0] dest, logic [TYPE_W-1:0] mtype,
                                          logic [DATA_W-1:0] payload,
                                          logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] rmax);
        t_in_data d;
        d                = '0;
        d.caller_pid     = caller;
        d.caller_may_ipc = may_ipc;
        d.dest_pid       = dest;
        d.msg_type       = mtype;
        d.payload        = payload;
        d.payload_size   = size;
        d.receive_max    = rmax;
        return d;
    endfunction

    function automatic t_in_data random_fields(logic [PID_W-1:0] caller, logic [PID_W-1:0] dest);
        return pack_req(caller, $urandom_range(0, 15) != 0, dest, $urandom,
                        {$urandom, $urandom}, SIZE_W'($urandom_range(0, 15)),
                        SIZE_W'($urandom_range(0, 15)));
    endfunction

    // Mostly known pids, some pid zero, some never seen before
    function automatic logic [PID_W-1:0] pick_pid(int fresh_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < fresh_pct) return PID_W'($urandom_range(1, 16'hFFFF));
        if (r < fresh_pct + 6) return '0;
        return pid_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
    endfunction

    // Bursts of sends to one mailbox followed by receives from it, mixed with
    // single requests of random kind
    task automatic run_traffic(input int n_items, input int fresh_pct, input int noise_pct);
        int               stop_at;
        int               burst;
        logic [PID_W-1:0] pid;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                offer(logic'($urandom_range(0, 1)),
                      random_fields(pick_pid(fresh_pct), pick_pid(fresh_pct)));
            end else begin
                pid   = pick_pid(fresh_pct);
                burst = $urandom_range(1, 18);
                repeat (burst) offer(KIND_SEND, random_fields(PID_W'($urandom), pid));
                burst = $urandom_range(1, 18);
                repeat (burst) offer(KIND_RECV, random_fields(pid, PID_W'($urandom)));
            end
        end
    endtask

    initial begin : stimulus
        int owned;
        pid_pool[0] = 16'hFFFF;
        pid_pool[1] = 16'h0001;
        for (int k = 2; k < POOL_SIZE; k++) begin
            pid_pool[k] = PID_W'($urandom_range(2, 16'hFFFE));
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: missing IPC right on both kinds
        offer(KIND_RECV, pack_req(16'hFFFF, 1'b0, 16'hFFFF, '1, '1, 4'hF, 4'hF));
        offer(KIND_SEND, pack_req(16'hFFFF, 1'b0, 16'hFFFF, '1, '1, 4'hF, 4'hF));
        // empty receive claims a mailbox for the caller
        offer(KIND_RECV, pack_req(16'h0005, 1'b1, 16'h0000, '0, '0, 4'h0, 4'hF));
        // oversize payload, all-zero message, plain message, short message to pid FFFF
        offer(KIND_SEND, pack_req(16'hFFFF, 1'b1, 16'h0005, '1, '1, 4'hF, 4'h0));
        offer(KIND_SEND, pack_req(16'h0000, 1'b1, 16'h0005, '0, '0, 4'h0, 4'h0));
        offer(KIND_SEND, pack_req(16'h1234, 1'b1, 16'h0005, 32'hA5C3_0F81,
                                  64'h0123_4567_89AB_CDEF, 4'h8, 4'h0));
        offer(KIND_SEND, pack_req(16'hABCD, 1'b1, 16'hFFFF, 32'h8000_0001,
                                  64'hFEDC_BA98_7654_3210, 4'h3, 4'h0));
        // receives with full, zero and clipped copy lengths
        offer(KIND_RECV, pack_req(16'h0005, 1'b1, 16'h0000, '0, '0, 4'h0, 4'hF));
        offer(KIND_RECV, pack_req(16'h0005, 1'b1, 16'h0000, '0, '0, 4'h0, 4'h0));
        offer(KIND_RECV, pack_req(16'h0005, 1'b1, 16'h0000, '0, '0, 4'h0, 4'h4));
        offer(KIND_RECV, pack_req(16'hFFFF, 1'b1, 16'h0000, '0, '0, 4'h0, 4'h2));
        // pid zero uses the lowest free mailbox without owning it
        offer(KIND_SEND, pack_req(16'h7777, 1'b1, 16'h0000, 32'h0000_0001, '1, 4'h5, 4'h0));
        offer(KIND_RECV, pack_req(16'h0000, 1'b1, 16'h0000, '0, '0, 4'h0, 4'hF));
        offer(KIND_RECV, pack_req(16'h0000, 1'b1, 16'h0000, '0, '0, 4'h0, 4'hF));
        offer(KIND_SEND, pack_req(16'h2222, 1'b1, 16'h0000, 32'h5A5A_5A5A, '1, 4'h6, 4'h0));
        // a new owner takes that slot and resets its queue
        offer(KIND_RECV, pack_req(16'h0009, 1'b1, 16'h0000, '0, '0, 4'h0, 4'hF));
        drain();

        // give every pool pid a mailbox before slots run out
        for (int k = 0; k < POOL_SIZE; k++) begin
            offer(KIND_RECV, random_fields(pid_pool[k], PID_W'($urandom)));
        end

        // Main traffic with a long hold-off at the output midway
        run_traffic(250, 3, 30);
        hold_off_cycles = HOLD_CYCLES;
        run_traffic(250, 3, 30);
        drain();

        // Many new pids: use up all mailboxes, then hit the no-mailbox case
        run_traffic(300, 40, 70);

        // Tail without any idling
        quiet_tail = 1'b1;
        run_traffic(200, 10, 40);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        owned = 0;
        for (int k = 0; k < MAILBOXES; k++) begin
            if (shadow.owner[k] != '0) owned++;
        end
        $display("%0d requests: %0d ok, %0d without IPC right, %0d no mailbox, %0d empty queue",
                 items_sent, shadow.status_seen[STS_OK], shadow.status_seen[STS_NO_CAP],
                 shadow.status_seen[STS_NO_MBOX], shadow.status_seen[STS_EMPTY]);
        $display("%0d sends dropped on a full queue, %0d of %0d mailboxes owned at the end",
                 shadow.full_drops, owned, MAILBOXES);
        if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
            $display("per_process_mailbox_queue_core_tb: PASS");
        end else begin
            $display("per_process_mailbox_queue_core_tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/ppmq_pkg.sv
hdl/ppmq_ram.sv
hdl/ppmq_owner_cam.sv
hdl/per_process_mailbox_queue_core.sv
dv/per_process_mailbox_queue_core_tb.sv
